>>> src/prit_pkg.sv
// prit_pkg: shared types and constants of the pulse repetition interval transform block
// configuration record, controller command and status records, register indexes, cordic table
// no dependencies
package prit_pkg;

  typedef enum logic [2:0] {
    REG_MIN_PRI      = 3'd0,
    REG_MAX_PRI      = 3'd1,
    REG_BIN_WIDTH    = 3'd2,
    REG_GAIN_PERIOD  = 3'd3,
    REG_GAIN_COUNT   = 3'd4,
    REG_GAIN_NOISE   = 3'd5,
    REG_OBSERVE_TIME = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [23:0] min_pri;
    logic [23:0] max_pri;
    logic [19:0] bin_width;
    logic [15:0] gain_period;
    logic [15:0] gain_count;
    logic [15:0] gain_noise;
    logic [31:0] observe_time;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic st_rd;
    logic calc_d;
    logic div_bin;
    logic div_mod;
    logic div_ph;
    logic div_r;
    logic div_t1;
    logic take_bin;
    logic cordic_go;
    logic hist_wr;
    logic dec_j;
    logic store;
    logic sqrt_r;
    logic sqrt_m;
    logic take_r;
    logic mul1;
    logic mul2;
    logic take_t1;
    logic sq_clr;
    logic sq_step;
    logic th_upd;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic j_last;
    logic d_over;
    logic d_inrange;
    logic bin_ok;
    logic div_done;
    logic cordic_done;
    logic sqrt_done;
    logic sq_last;
    logic full;
    logic empty;
    logic last_q;
    logic out_free;
    logic last_i;
  } ctrl_status_t;

  localparam logic [19:0] MinBinWidth = 20'd1;
  localparam logic [31:0] MinObserve  = 32'd1;
  localparam logic [32:0] CordicGain  = 33'd652032874;

  function automatic logic [29:0] atan_f(input logic [3:0] idx);
    logic [29:0] v;
    case (idx)
      4'd0:    v = 30'd536870912;
      4'd1:    v = 30'd316933406;
      4'd2:    v = 30'd167458907;
      4'd3:    v = 30'd85004756;
      4'd4:    v = 30'd42667331;
      4'd5:    v = 30'd21354465;
      4'd6:    v = 30'd10679838;
      4'd7:    v = 30'd5340245;
      4'd8:    v = 30'd2670163;
      4'd9:    v = 30'd1335087;
      4'd10:   v = 30'd667544;
      4'd11:   v = 30'd333772;
      4'd12:   v = 30'd166886;
      4'd13:   v = 30'd83443;
      4'd14:   v = 30'd41722;
      default: v = 30'd20861;
    endcase
    return v;
  endfunction

endpackage

>>> src/prit_div.sv
// prit_div: radix-2 restoring divider, one quotient bit per cycle
// dividend bits shift in from the top of num_i after an initial remainder; uses prit_pkg
module prit_div import prit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rem0_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  input  logic [6:0]  steps_i,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o,
  output logic        done_o
);

  logic [31:0] rem_q, den_q;
  logic [63:0] num_q, quo_q;
  logic [6:0]  cnt_q;
  logic        run_q, done_q;
  logic [32:0] rem_sh, rem_nx;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, num_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= steps_i;
      end else if (run_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem0_i;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (run_q) begin
      rem_q <= rem_nx[31:0];
      num_q <= {num_q[62:0], 1'b0};
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

>>> src/prit_sqrt.sv
// prit_sqrt: digit-by-digit integer square root, one root bit per cycle
// 72-bit radicand, 36-bit floor root; uses prit_pkg
module prit_sqrt import prit_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [71:0] rad_i,
  output logic [35:0] root_o,
  output logic        done_o
);

  logic [71:0] rad_q;
  logic [35:0] root_q;
  logic [37:0] rem_q;
  logic [5:0]  cnt_q;
  logic        run_q, done_q;
  logic [39:0] rem_sh, trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[71:70]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd36;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (run_q) begin
      rad_q  <= {rad_q[69:0], 2'b00};
      root_q <= {root_q[34:0], ge};
      rem_q  <= ge ? 38'(rem_sh - trial) : rem_sh[37:0];
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

>>> src/prit_dp.sv
// prit_dp: datapath with arrival memory, histogram memory, divider, cordic, squarer, square root
// driven by ctrl_cmd_t from prit_ctrl; uses prit_pkg, prit_div, prit_sqrt
module prit_dp import prit_pkg::*; #(
  parameter int BINS       = 64,
  parameter int MAX_PULSES = 1024,
  parameter int PHASE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic [31:0]  arrival_time_i,
  input  logic         last_pulse_i,
  input  ctrl_cmd_t    cmd_i,
  output ctrl_status_t status_o,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [5:0]   bin_index_o,
  output logic [31:0]  bin_center_o,
  output logic [33:0]  magnitude_o,
  output logic [47:0]  threshold_o,
  output logic         detected_o,
  output logic         last_bin_o
);

  localparam int AW = $clog2(MAX_PULSES);
  localparam int CW = $clog2(MAX_PULSES + 1);
  localparam int BW = $clog2(BINS);

  logic [19:0] w;
  logic [31:0] t_obs;
  assign w     = (cfg_i.bin_width == '0) ? MinBinWidth : cfg_i.bin_width;
  assign t_obs = (cfg_i.observe_time == '0) ? MinObserve : cfg_i.observe_time;

  logic [31:0]   toa_q;
  logic          last_q;
  logic [CW-1:0] total_q, j_q, jm1;
  logic          full;
  logic [31:0]   d_q;
  logic [23:0]   dm;
  logic [BW-1:0] bin_q, i_q;

  assign jm1  = j_q - CW'(1);
  assign full = total_q == CW'(MAX_PULSES);
  assign dm   = d_q[23:0] - cfg_i.min_pri;

  // arrival memory
  logic [31:0] store_mem [MAX_PULSES];
  logic [31:0] srd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && !full) begin
      store_mem[total_q[AW-1:0]] <= toa_q;
    end
    if (cmd_i.st_rd) begin
      srd_q <= store_mem[jm1[AW-1:0]];
    end
  end

  // divider
  logic        div_start, div_done;
  logic [31:0] div_r0, div_den, div_rem;
  logic [63:0] div_num, div_quo;
  logic [6:0]  div_steps;
  logic [47:0] gpt_q;
  logic [26:0] oddw;
  logic [27:0] center2;

  assign oddw    = 27'({i_q, 1'b1}) * 27'(w);
  assign center2 = 28'({cfg_i.min_pri, 1'b0}) + 28'(oddw);

  always_comb begin
    div_r0    = '0;
    div_num   = '0;
    div_den   = '0;
    div_steps = '0;
    if (cmd_i.div_bin) begin
      div_num   = {dm, 40'b0};
      div_den   = {12'b0, w};
      div_steps = 7'd24;
    end else if (cmd_i.div_mod) begin
      div_num   = {toa_q, 32'b0};
      div_den   = d_q;
      div_steps = 7'd32;
    end else if (cmd_i.div_ph) begin
      div_r0    = div_rem;
      div_den   = d_q;
      div_steps = 7'(PHASE_BITS);
    end else if (cmd_i.div_r) begin
      div_num   = {4'b0, w, 40'b0};
      div_den   = t_obs;
      div_steps = 7'd64;
    end else if (cmd_i.div_t1) begin
      div_num   = {9'b0, gpt_q, 7'b0};
      div_den   = {4'b0, center2};
      div_steps = 7'd64;
    end
  end

  assign div_start = cmd_i.div_bin | cmd_i.div_mod | cmd_i.div_ph | cmd_i.div_r | cmd_i.div_t1;

  prit_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem0_i  (div_r0),
    .num_i   (div_num),
    .den_i   (div_den),
    .steps_i (div_steps),
    .quo_o   (div_quo),
    .rem_o   (div_rem),
    .done_o  (div_done)
  );

  // cordic
  logic [31:0]        ang, ang_rnd, ang_rem;
  logic [1:0]         quad, quad_q;
  logic signed [32:0] cx_q, cy_q, dx, dy, xr, yr;
  logic signed [33:0] cz_q, at;
  logic [3:0]         ck_q;
  logic               crun_q, cfin_q, cdone_q;
  logic signed [17:0] c_q, s_q;

  always_comb begin
    ang     = {div_quo[PHASE_BITS-1:0], {(32 - PHASE_BITS){1'b0}}};
    ang_rnd = ang + 32'h2000_0000;
    quad    = ang_rnd[31:30];
    ang_rem = ang - {quad, 30'b0};
    dx      = cy_q >>> ck_q;
    dy      = cx_q >>> ck_q;
    at      = $signed({4'b0, atan_f(ck_q)});
    xr      = (cx_q + 33'sd32768) >>> 16;
    yr      = (cy_q + 33'sd32768) >>> 16;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crun_q  <= 1'b0;
      cfin_q  <= 1'b0;
      cdone_q <= 1'b0;
      ck_q    <= '0;
    end else begin
      cfin_q  <= 1'b0;
      cdone_q <= cfin_q;
      if (cmd_i.cordic_go) begin
        crun_q <= 1'b1;
        ck_q   <= '0;
      end else if (crun_q) begin
        ck_q <= ck_q + 4'd1;
        if (ck_q == 4'd15) begin
          crun_q <= 1'b0;
          cfin_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_go) begin
      cx_q   <= $signed(CordicGain);
      cy_q   <= '0;
      cz_q   <= 34'($signed(ang_rem));
      quad_q <= quad;
    end else if (crun_q) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - dx;
        cy_q <= cy_q + dy;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + dx;
        cy_q <= cy_q - dy;
        cz_q <= cz_q + at;
      end
    end
    if (cfin_q) begin
      case (quad_q)
        2'd0: begin
          c_q <= xr[17:0];
          s_q <= yr[17:0];
        end
        2'd1: begin
          c_q <= -yr[17:0];
          s_q <= xr[17:0];
        end
        2'd2: begin
          c_q <= -xr[17:0];
          s_q <= -yr[17:0];
        end
        default: begin
          c_q <= yr[17:0];
          s_q <= -xr[17:0];
        end
      endcase
    end
  end

  // histogram memory: {count, sin sum, cos sum}
  logic [91:0]        hist_mem [BINS];
  logic [91:0]        hrd_q, hdata;
  logic               hv_q;
  logic [BINS-1:0]    hvalid_q;
  logic [BW-1:0]      haddr;
  logic signed [35:0] hc, hs;
  logic [19:0]        hn;

  assign haddr = cmd_i.cordic_go ? bin_q : i_q;
  assign hdata = hv_q ? hrd_q : '0;
  assign hc    = $signed(hdata[35:0]);
  assign hs    = $signed(hdata[71:36]);
  assign hn    = hdata[91:72];

  always_ff @(posedge clk_i) begin
    if (cmd_i.cordic_go || cmd_i.div_t1) begin
      hrd_q <= hist_mem[haddr];
    end
    if (cmd_i.hist_wr) begin
      hist_mem[bin_q] <= {hn + 20'd1, hs + 36'(s_q), hc + 36'(c_q)};
    end
  end

  // squares of the sums
  logic [35:0] ac, as_v, prod_q;
  logic [17:0] opa, opb;
  logic [5:0]  sh, sh_q;
  logic [2:0]  k_q;
  logic [71:0] acc_q;

  assign ac   = hc[35] ? 36'(-hc) : 36'(hc);
  assign as_v = hs[35] ? 36'(-hs) : 36'(hs);

  always_comb begin
    case (k_q)
      3'd0: begin
        opa = ac[17:0];    opb = ac[17:0];    sh = 6'd0;
      end
      3'd1: begin
        opa = ac[35:18];   opb = ac[17:0];    sh = 6'd19;
      end
      3'd2: begin
        opa = ac[35:18];   opb = ac[35:18];   sh = 6'd36;
      end
      3'd3: begin
        opa = as_v[17:0];  opb = as_v[17:0]; sh = 6'd0;
      end
      3'd4: begin
        opa = as_v[35:18]; opb = as_v[17:0]; sh = 6'd19;
      end
      default: begin
        opa = as_v[35:18]; opb = as_v[35:18]; sh = 6'd36;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_clr) begin
      acc_q <= '0;
    end else if (cmd_i.sq_step) begin
      if (k_q != 3'd0) begin
        acc_q <= acc_q + (72'(prod_q) << sh_q);
      end
      prod_q <= 36'(opa) * 36'(opb);
      sh_q   <= sh;
    end
  end

  // square root
  logic        sqrt_start, sqrt_done;
  logic [71:0] sqrt_rad;
  logic [35:0] root;

  assign sqrt_start = cmd_i.sqrt_r | cmd_i.sqrt_m;
  assign sqrt_rad   = cmd_i.sqrt_r ? {12'b0, div_quo[59:0]} : acc_q;

  prit_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sqrt_rad),
    .root_o  (root),
    .done_o  (sqrt_done)
  );

  // thresholds
  logic [29:0]        r_q;
  logic [16+CW-1:0]   m1_q;
  logic [16+CW+29:0]  m2;
  logic [35:0]        t2p;
  logic [47:0]        t1_q, t2_q, t3_q, th_q, th_a;
  logic [33:0]        mag;
  logic [25:0]        iw;
  logic               last_i;

  assign m2     = (16 + CW + 30)'(m1_q) * (16 + CW + 30)'(r_q);
  assign t2p    = 36'(cfg_i.gain_count) * 36'(hn);
  assign th_a   = (t2_q > t1_q) ? t2_q : t1_q;
  assign mag    = (root[35:34] != 2'b00) ? '1 : root[33:0];
  assign iw     = 26'(i_q) * 26'(w);
  assign last_i = i_q == BW'(BINS - 1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      toa_q <= arrival_time_i;
      last_q <= last_pulse_i;
    end
    if (cmd_i.calc_d) begin
      d_q <= toa_q - srd_q;
    end
    if (cmd_i.take_bin) begin
      bin_q <= div_quo[BW-1:0];
    end
    if (cmd_i.take_r) begin
      r_q <= root[29:0];
    end
    if (cmd_i.mul1) begin
      m1_q  <= (16 + CW)'(cfg_i.gain_noise) * (16 + CW)'(total_q);
      gpt_q <= 48'(cfg_i.gain_period) * 48'(t_obs);
    end
    if (cmd_i.mul2) begin
      t3_q <= 48'(m2 >> 14);
    end
    if (cmd_i.take_t1) begin
      t1_q <= (div_quo[63:48] != '0) ? '1 : div_quo[47:0];
    end
    if (cmd_i.sq_clr) begin
      t2_q <= {6'b0, t2p, 6'b0};
    end
    if (cmd_i.th_upd) begin
      th_q <= (t3_q > th_a) ? t3_q : th_a;
    end
    if (cmd_i.emit) begin
      bin_index_o  <= 6'(i_q);
      bin_center_o <= 32'(cfg_i.min_pri) + 32'(iw) + 32'(w[19:1]);
      magnitude_o  <= mag;
      threshold_o  <= th_q;
      detected_o   <= {14'b0, mag} > th_q;
      last_bin_o   <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      j_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      hv_q        <= 1'b0;
      hvalid_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        j_q <= total_q;
      end else if (cmd_i.dec_j) begin
        j_q <= jm1;
      end
      if (cmd_i.store && !full) begin
        total_q <= total_q + CW'(1);
      end
      if (cmd_i.cordic_go || cmd_i.div_t1) begin
        hv_q <= hvalid_q[haddr];
      end
      if (cmd_i.hist_wr) begin
        hvalid_q[bin_q] <= 1'b1;
      end
      if (cmd_i.sq_clr) begin
        k_q <= '0;
      end else if (cmd_i.sq_step) begin
        k_q <= k_q + 3'd1;
      end
      if (cmd_i.emit) begin
        out_valid_o <= 1'b1;
        if (last_i) begin
          i_q      <= '0;
          total_q  <= '0;
          hvalid_q <= '0;
        end else begin
          i_q <= i_q + BW'(1);
        end
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_comb begin
    status_o.j_last      = j_q == CW'(1);
    status_o.d_over      = d_q > {8'b0, cfg_i.max_pri};
    status_o.d_inrange   = (d_q > {8'b0, cfg_i.min_pri}) && (d_q < {8'b0, cfg_i.max_pri});
    status_o.bin_ok      = div_quo < 64'(BINS);
    status_o.div_done    = div_done;
    status_o.cordic_done = cdone_q;
    status_o.sqrt_done   = sqrt_done;
    status_o.sq_last     = k_q == 3'd6;
    status_o.full        = full;
    status_o.empty       = total_q == '0;
    status_o.last_q      = last_q;
    status_o.out_free    = !out_valid_o || out_ready_i;
    status_o.last_i      = last_i;
  end

endmodule

>>> src/prit_ctrl.sv
// prit_ctrl: sequencer for the pair walk and the per-bin report
// issues ctrl_cmd_t to prit_dp and follows ctrl_status_t; uses prit_pkg
module prit_ctrl import prit_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    cmd_o
);

  typedef enum logic [20:0] {
    ST_IDLE  = 21'd1,
    ST_RD    = 21'd2,
    ST_DLY   = 21'd4,
    ST_DIFF  = 21'd8,
    ST_BDIV  = 21'd16,
    ST_MDIV  = 21'd32,
    ST_PDIV  = 21'd64,
    ST_CORD  = 21'd128,
    ST_ACC   = 21'd256,
    ST_NEXT  = 21'd512,
    ST_STORE = 21'd1024,
    ST_RDIV  = 21'd2048,
    ST_RSQ   = 21'd4096,
    ST_MUL1  = 21'd8192,
    ST_MUL2  = 21'd16384,
    ST_BIN   = 21'd32768,
    ST_T1    = 21'd65536,
    ST_SQ    = 21'd131072,
    ST_MGO   = 21'd262144,
    ST_MSQ   = 21'd524288,
    ST_EMIT  = 21'd1048576
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = (!status_i.full && !status_i.empty) ? ST_RD : ST_STORE;
        end
      end
      ST_RD: begin
        cmd_o.st_rd = 1'b1;
        state_d = ST_DLY;
      end
      ST_DLY: begin
        cmd_o.calc_d = 1'b1;
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        if (status_i.d_over) begin
          state_d = ST_STORE;
        end else if (status_i.d_inrange) begin
          cmd_o.div_bin = 1'b1;
          state_d = ST_BDIV;
        end else begin
          state_d = ST_NEXT;
        end
      end
      ST_BDIV: begin
        if (status_i.div_done) begin
          if (status_i.bin_ok) begin
            cmd_o.take_bin = 1'b1;
            cmd_o.div_mod = 1'b1;
            state_d = ST_MDIV;
          end else begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_MDIV: begin
        if (status_i.div_done) begin
          cmd_o.div_ph = 1'b1;
          state_d = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (status_i.div_done) begin
          cmd_o.cordic_go = 1'b1;
          state_d = ST_CORD;
        end
      end
      ST_CORD: begin
        if (status_i.cordic_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.hist_wr = 1'b1;
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.dec_j = 1'b1;
        state_d = status_i.j_last ? ST_STORE : ST_RD;
      end
      ST_STORE: begin
        cmd_o.store = 1'b1;
        if (status_i.last_q) begin
          cmd_o.div_r = 1'b1;
          state_d = ST_RDIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RDIV: begin
        if (status_i.div_done) begin
          cmd_o.sqrt_r = 1'b1;
          state_d = ST_RSQ;
        end
      end
      ST_RSQ: begin
        if (status_i.sqrt_done) begin
          cmd_o.take_r = 1'b1;
          state_d = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d = ST_BIN;
      end
      ST_BIN: begin
        cmd_o.div_t1 = 1'b1;
        state_d = ST_T1;
      end
      ST_T1: begin
        if (status_i.div_done) begin
          cmd_o.take_t1 = 1'b1;
          cmd_o.sq_clr = 1'b1;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd_o.sq_step = 1'b1;
        if (status_i.sq_last) begin
          state_d = ST_MGO;
        end
      end
      ST_MGO: begin
        cmd_o.sqrt_m = 1'b1;
        cmd_o.th_upd = 1'b1;
        state_d = ST_MSQ;
      end
      ST_MSQ: begin
        cmd_o.th_upd = 1'b1;
        if (status_i.sqrt_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d = status_i.last_i ? ST_IDLE : ST_BIN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/pri_transform_histogram_top.sv
// Pulse repetition interval transform histogram. Each request carries one arrival time; the
// block walks back over the stored arrivals, newest first, with one shared radix-2 divider and
// an iterative 16-step cordic. A pair that lands in a bin takes a 24-step bin divide, a 32-step
// modulo divide, a PHASE_BITS-step phase divide and the cordic; a pair inside the range but
// past the last bin takes only the bin divide, and a pair outside the bins takes no divide.
// A request with last_pulse set then reports a noise term (64-step divide, 36-step root) and,
// per bin, a period term (64-step divide), squaring and a 36-step root; the report waits while
// the result side stalls. Results are held in an output register, so a new request is taken
// as soon as the last bin is loaded.
// top level: configuration registers, prit_ctrl and prit_dp; uses prit_pkg
module pri_transform_histogram_top import prit_pkg::*; #(
  parameter int BINS       = 64,
  parameter int MAX_PULSES = 1024,
  parameter int PHASE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] arrival_time_i,
  input  logic        last_pulse_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  bin_index_o,
  output logic [31:0] bin_center_o,
  output logic [33:0] magnitude_o,
  output logic [47:0] threshold_o,
  output logic        detected_o,
  output logic        last_bin_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t         cfg_q;
  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pri      <= 24'd100;
      cfg_q.max_pri      <= 24'd6500;
      cfg_q.bin_width    <= 20'd100;
      cfg_q.gain_period  <= 16'd256;
      cfg_q.gain_count   <= 16'd256;
      cfg_q.gain_noise   <= 16'd256;
      cfg_q.observe_time <= 32'd1000000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MIN_PRI:      cfg_q.min_pri      <= cfg_data_i[23:0];
        REG_MAX_PRI:      cfg_q.max_pri      <= cfg_data_i[23:0];
        REG_BIN_WIDTH:    cfg_q.bin_width    <= cfg_data_i[19:0];
        REG_GAIN_PERIOD:  cfg_q.gain_period  <= cfg_data_i[15:0];
        REG_GAIN_COUNT:   cfg_q.gain_count   <= cfg_data_i[15:0];
        REG_GAIN_NOISE:   cfg_q.gain_noise   <= cfg_data_i[15:0];
        REG_OBSERVE_TIME: cfg_q.observe_time <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  prit_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prit_dp #(
    .BINS       (BINS),
    .MAX_PULSES (MAX_PULSES),
    .PHASE_BITS (PHASE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .arrival_time_i (arrival_time_i),
    .last_pulse_i   (last_pulse_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .bin_index_o    (bin_index_o),
    .bin_center_o   (bin_center_o),
    .magnitude_o    (magnitude_o),
    .threshold_o    (threshold_o),
    .detected_o     (detected_o),
    .last_bin_o     (last_bin_o)
  );

endmodule

>>> tb/pri_transform_histogram_top_tb.sv
// pri_transform_histogram_top_tb: self-checking testbench of the pri transform histogram block
// random bursty pulse sets and stalls on the result side, bin reports checked against a predictor
// depends on prit_pkg and pri_transform_histogram_top
module pri_transform_histogram_top_tb import prit_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BINS       = 64;
  localparam int MAX_PULSES = 64;
  localparam int PHASE_BITS = 12;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam longint unsigned MASK34 = 64'h3_FFFF_FFFF;
  localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;

  typedef struct {
    bit [31:0] arrival;
    bit        last;
  } pulse_t;

  typedef struct {
    bit [5:0]  index;
    bit [31:0] center;
    bit [33:0] magnitude;
    bit [47:0] threshold;
    bit        detected;
    bit        last_bin;
  } bin_report_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [31:0] arrival_time_i;
  logic        last_pulse_i;
  logic        out_valid_o, out_ready_i;
  logic [5:0]  bin_index_o;
  logic [31:0] bin_center_o;
  logic [33:0] magnitude_o;
  logic [47:0] threshold_o;
  logic        detected_o, last_bin_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  pri_transform_histogram_top #(
    .BINS(BINS), .MAX_PULSES(MAX_PULSES), .PHASE_BITS(PHASE_BITS)
  ) uut (.*);

  // predictor state
  int unsigned     min_pri, max_pri, bin_width, gain_period, gain_count, gain_noise, observe_time;
  bit [31:0]       arrival_store [MAX_PULSES];
  int unsigned     pulse_total;
  longint          cos_sums [BINS];
  longint          sin_sums [BINS];
  int unsigned     pair_counts [BINS];

  pulse_t          pending_pulses[$];
  bin_report_t     expected_bins[$];
  int unsigned     errors;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic bit [36:0] isqrt(bit [127:0] v);
    bit [36:0]  res;
    bit [127:0] cand;
    res = '0;
    for (int b = 36; b >= 0; b--) begin
      cand = 128'(res | (37'd1 << b));
      if (cand * cand <= v) res = 37'(cand);
    end
    return res;
  endfunction

  task automatic cordic_cos_sin(input bit [31:0] a, output longint c, output longint s);
    bit [31:0] q, rem;
    longint    z, x, y, dx, dy, xc, yc;
    q = ((a + 32'h2000_0000) >> 30) & 32'd3;
    rem = a - (q << 30);
    z = longint'($signed(rem));
    x = longint'(CordicGain);
    y = 0;
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_f(4'(i)));
      end else begin
        x += dx; y -= dy; z += longint'(atan_f(4'(i)));
      end
    end
    xc = (x + 32768) >>> 16;
    yc = (y + 32768) >>> 16;
    case (q)
      0: begin c = xc;  s = yc;  end
      1: begin c = -yc; s = xc;  end
      2: begin c = -xc; s = -yc; end
      default: begin c = yc; s = -xc; end
    endcase
  endtask

  task automatic predict_pulse(input bit [31:0] toa, input bit last);
    bit [31:0]       d;
    longint unsigned w, t, bin, ph;
    longint          c, s;
    bit [127:0]      r, t1, t2, t3, th, center2, cabs, sabs, mag;
    bin_report_t     rep;
    w = (bin_width != 0) ? bin_width : 1;
    t = (observe_time != 0) ? observe_time : 1;
    if (pulse_total < MAX_PULSES) begin
      for (int j = pulse_total; j > 0; j--) begin
        d = toa - arrival_store[j-1];
        if (d > max_pri) break;
        if (d > min_pri && d < max_pri) begin
          bin = longint'(d - min_pri) / w;
          if (bin < BINS) begin
            ph = (longint'(toa % d) << PHASE_BITS) / longint'(d);
            cordic_cos_sin(32'(ph << (32 - PHASE_BITS)), c, s);
            cos_sums[bin] += c;
            sin_sums[bin] += s;
            pair_counts[bin]++;
          end
        end
      end
      arrival_store[pulse_total] = toa;
      pulse_total++;
    end
    if (!last) return;
    r = 128'(isqrt((128'(w) << 40) / 128'(t)));
    t3 = (128'(gain_noise) * 128'(pulse_total) * 128'd64 * r) >> 20;
    for (int i = 0; i < BINS; i++) begin
      center2 = 128'(2 * longint'(min_pri)) + 128'(2 * i + 1) * 128'(w);
      t1 = (128'(gain_period) * 128'(t) * 128'd128) / center2;
      t2 = 128'(gain_count) * 128'(pair_counts[i]) * 128'd64;
      th = t1;
      if (t2 > th) th = t2;
      if (t3 > th) th = t3;
      if (th > 128'(MASK48)) th = 128'(MASK48);
      cabs = 128'((cos_sums[i] < 0) ? -cos_sums[i] : cos_sums[i]);
      sabs = 128'((sin_sums[i] < 0) ? -sin_sums[i] : sin_sums[i]);
      mag = 128'(isqrt(cabs * cabs + sabs * sabs));
      if (mag > 128'(MASK34)) mag = 128'(MASK34);
      rep.index = 6'(i);
      rep.center = 32'(longint'(min_pri) + longint'(i) * w + w / 2);
      rep.magnitude = 34'(mag);
      rep.threshold = 48'(th);
      rep.detected = mag > th;
      rep.last_bin = (i == BINS - 1);
      expected_bins.insert(expected_bins.size(), rep);
      cos_sums[i] = 0;
      sin_sums[i] = 0;
      pair_counts[i] = 0;
    end
    pulse_total = 0;
  endtask

  // driver
  int unsigned burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      arrival_time_i <= '0;
      last_pulse_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid_i && in_ready_o) predict_pulse(arrival_time_i, last_pulse_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_pulses.size() != 0) begin
          arrival_time_i <= pending_pulses[0].arrival;
          last_pulse_i <= pending_pulses[0].last;
          void'(pending_pulses.pop_front());
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0h expected %0h", field, got, want);
    errors++;
  endtask

  // monitor and result-side stalls
  int unsigned stall_mode, stall_run;
  always @(posedge clk_i or negedge rst_ni) begin
    bin_report_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode <= 0;
      stall_run <= 0;
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_bins.size() == 0) begin
          report_mismatch("unexpected bin", bin_index_o, 0);
        end else begin
          want = expected_bins.pop_front();
          if (bin_index_o !== want.index) report_mismatch("bin_index", bin_index_o, want.index);
          if (bin_center_o !== want.center) report_mismatch("bin_center", bin_center_o, want.center);
          if (magnitude_o !== want.magnitude)
            report_mismatch("magnitude", magnitude_o, want.magnitude);
          if (threshold_o !== want.threshold)
            report_mismatch("threshold", threshold_o, want.threshold);
          if (detected_o !== want.detected) report_mismatch("detected", detected_o, want.detected);
          if (last_bin_o !== want.last_bin) report_mismatch("last_bin", last_bin_o, want.last_bin);
        end
      end
      if (cycles[8:0] == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= $urandom_range(0, 1);
        default: begin
          if (stall_run == 0) begin
            stall_run <= $urandom_range(1, 30);
            out_ready_i <= ~out_ready_i;
          end else begin
            stall_run <= stall_run - 1;
          end
        end
      endcase
    end
  end

  // configuration channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input bit [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_MIN_PRI:      min_pri = data[23:0];
      REG_MAX_PRI:      max_pri = data[23:0];
      REG_BIN_WIDTH:    bin_width = data[19:0];
      REG_GAIN_PERIOD:  gain_period = data[15:0];
      REG_GAIN_COUNT:   gain_count = data[15:0];
      REG_GAIN_NOISE:   gain_noise = data[15:0];
      default:          observe_time = data;
    endcase
  endtask

  task automatic configure(input bit [31:0] mn, mx, bw, gp, gc, gn, ot);
    write_reg(REG_MIN_PRI, mn);
    write_reg(REG_MAX_PRI, mx);
    write_reg(REG_BIN_WIDTH, bw);
    write_reg(REG_GAIN_PERIOD, gp);
    write_reg(REG_GAIN_COUNT, gc);
    write_reg(REG_GAIN_NOISE, gn);
    write_reg(REG_OBSERVE_TIME, ot);
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_pulses.size() != 0 || in_valid_i || expected_bins.size() != 0);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic push_pulse(input bit [31:0] toa, input bit last);
    pulse_t p;
    p.arrival = toa;
    p.last = last;
    pending_pulses.insert(pending_pulses.size(), p);
  endtask

  // one pulse set, mostly with spacings that land in the histogram
  task automatic push_set(input int n);
    bit [31:0]       toa;
    longint unsigned w, hi;
    w = (bin_width != 0) ? bin_width : 1;
    hi = longint'(min_pri) + 70 * w;
    if (hi > max_pri) hi = max_pri;
    if (hi < 1) hi = 1;
    if (hi > 32'h7FFF_FFFF) hi = 32'h7FFF_FFFF;
    toa = $urandom;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: toa = toa - $urandom_range(1, 5000);
        1: toa = toa + $urandom;
        default: toa = toa + 32'($urandom_range(1, 32'(hi)));
      endcase
      push_pulse(toa, k == n - 1);
    end
  endtask

  initial begin
    bit [31:0] base;
    min_pri = 100; max_pri = 6500; bin_width = 100;
    gain_period = 256; gain_count = 256; gain_noise = 256; observe_time = 1000000;
    pulse_total = 0;
    foreach (cos_sums[i]) begin
      cos_sums[i] = 0; sin_sums[i] = 0; pair_counts[i] = 0;
    end
    errors = 0;
    @(posedge rst_ni);
    repeat (3) @(posedge clk_i);
    configure(100, 6500, 100, 256, 256, 256, 1000000);

    // directed: field extremes, boundaries of the interval window, descending and wrapping times
    push_pulse(32'h0, 1'b0);
    push_pulse(32'd100, 1'b0);
    push_pulse(32'd201, 1'b0);
    push_pulse(32'd6500, 1'b0);
    push_pulse(32'd6601, 1'b0);
    push_pulse(32'd13101, 1'b0);
    push_pulse(32'd13000, 1'b0);
    push_pulse(32'd19000, 1'b1);
    push_pulse(32'hFFFF_F000, 1'b0);
    push_pulse(32'hFFFF_FFFF, 1'b0);
    push_pulse(32'h0000_0400, 1'b0);
    push_pulse(32'h0000_0C00, 1'b1);
    push_pulse(32'h8000_0000, 1'b1);
    wait_idle();

    // sender holds off until every bin of the report has come back
    for (int k = 0; k < 4; k++) begin
      push_set($urandom_range(2, 10));
      wait_idle();
    end

    // store fills up: spacing beyond max_pri keeps the walk short
    base = 32'd1000;
    for (int k = 0; k < MAX_PULSES + 6; k++) begin
      base = base + $urandom_range(7000, 20000);
      push_pulse(base, k == MAX_PULSES + 5);
    end
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: configure(0, 24'hFF_FFFF, 0, 0, 0, 0, 0);
        1: configure(24'hFF_FFFF, 0, 20'hF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        2: configure(0, 6400, 100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1);
        3: configure(0, 24'hFF_FFFF, 1, $urandom, $urandom, $urandom, $urandom);
        default: begin
          base = $urandom_range(0, 2000);
          configure(base, base + $urandom_range(1, 30000), $urandom_range(1, 500),
                    $urandom, $urandom, $urandom, $urandom);
        end
      endcase
      for (int k = 0; k < 2; k++) push_set($urandom_range(2, 12));
      wait_idle();
    end

    if (errors == 0 && expected_bins.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
